// ===== rtl/ipru_pkg.sv =====
// Shared types, constants and helper functions of the pixel replication upscaler.
package ipru_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int SCALE_W   = 7;
    localparam int WIDTH_W   = 11;
    localparam int PIXEL_W   = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;
    localparam int OUSER_W   = 3;

    localparam logic [SCALE_W-1:0] SCALE_MIN   = SCALE_W'(1);
    localparam logic [SCALE_W-1:0] SCALE_MAX   = SCALE_W'(100);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(1);
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = WIDTH_W'(MAX_WIDTH);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

    // Command codes carried in the input tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // Bit positions in the output tuser.
    localparam int OUSER_PIXEL_VALID = 0;
    localparam int OUSER_END_BLOCK   = 1;
    localparam int OUSER_REJECTED    = 2;

    // Per-item flags travelling alongside the line store read.
    typedef struct packed {
        logic pixel_valid;
        logic end_of_line;
        logic end_of_block;
        logic load_rejected;
    } t_meta;

    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] r;
        r = s;
        if (s < SCALE_MIN) r = SCALE_MIN;
        else if (s > SCALE_MAX) r = SCALE_MAX;
        return r;
    endfunction

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w < WIDTH_MIN) r = WIDTH_MIN;
        else if (w > WIDTH_LIMIT) r = WIDTH_LIMIT;
        return r;
    endfunction

endpackage

// ===== rtl/ipru_line_ram.sv =====
// Simple dual-port line store with one write port and a registered read port.
module ipru_line_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [0:(1 << ADDR_BITS)-1];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read data holds while no read is issued, so a stalled consumer keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ipru_ctrl.sv =====
// Configuration registers, load and replay counters, and line store access control.
module ipru_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ipru_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipru_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_item_en,
    input  logic                           i_command,
    input  logic [ipru_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                           o_wr_en,
    output logic [ipru_pkg::ADDR_W-1:0]    o_wr_addr,
    output logic [ipru_pkg::PIXEL_W-1:0]   o_wr_data,
    output logic                           o_rd_en,
    output logic [ipru_pkg::ADDR_W-1:0]    o_rd_addr,
    output ipru_pkg::t_meta                o_meta
);
    import ipru_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    logic [WIDTH_W-1:0] r_width;
    logic [CNT_W-1:0]   r_loaded, n_loaded;
    logic               r_replay, n_replay;
    logic [ADDR_W-1:0]  r_src, n_src;
    logic [SCALE_W-1:0] r_hrep, n_hrep;
    logic [SCALE_W-1:0] r_vrep, n_vrep;

    logic [SCALE_W-1:0] scale;
    logic [WIDTH_W-1:0] width;
    logic [CNT_W-1:0]   loaded_inc;
    logic               last_h;
    logic               eol;
    logic               eob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= WIDTH_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                REG_WIDTH: r_width <= i_cfg_data[WIDTH_W-1:0];
                default:   ;
            endcase
        end
    end

    assign scale      = eff_scale(r_scale);
    assign width      = eff_width(r_width);
    assign loaded_inc = r_loaded + CNT_W'(1);
    assign last_h     = ({1'b0, r_hrep} + (SCALE_W+1)'(1)) >= {1'b0, scale};
    assign eol        = last_h && (({1'b0, r_src} + CNT_W'(1)) >= CNT_W'(width));
    assign eob        = eol && (({1'b0, r_vrep} + (SCALE_W+1)'(1)) >= {1'b0, scale});

    always_comb begin
        n_loaded = r_loaded;
        n_replay = r_replay;
        n_src    = r_src;
        n_hrep   = r_hrep;
        n_vrep   = r_vrep;
        o_wr_en  = 1'b0;
        o_rd_en  = 1'b0;
        o_meta   = '0;
        if (i_item_en) begin
            if (i_command == CMD_LOAD) begin
                if (r_replay) begin
                    o_meta.load_rejected = 1'b1;
                end else begin
                    // Entries past the end of the store are counted but not kept.
                    o_wr_en  = !r_loaded[CNT_W-1];
                    n_loaded = loaded_inc;
                    if (loaded_inc >= CNT_W'(width)) begin
                        n_replay = 1'b1;
                        n_src    = '0;
                        n_hrep   = '0;
                        n_vrep   = '0;
                    end
                end
            end else if (r_replay) begin
                o_rd_en             = 1'b1;
                o_meta.pixel_valid  = 1'b1;
                o_meta.end_of_line  = eol;
                o_meta.end_of_block = eob;
                if (!last_h) begin
                    n_hrep = r_hrep + SCALE_W'(1);
                end else begin
                    n_hrep = '0;
                    if (!eol) begin
                        n_src = r_src + ADDR_W'(1);
                    end else begin
                        n_src = '0;
                        if (!eob) begin
                            n_vrep = r_vrep + SCALE_W'(1);
                        end else begin
                            n_vrep   = '0;
                            n_replay = 1'b0;
                            n_loaded = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_replay <= 1'b0;
            r_src    <= '0;
            r_hrep   <= '0;
            r_vrep   <= '0;
        end else begin
            r_loaded <= n_loaded;
            r_replay <= n_replay;
            r_src    <= n_src;
            r_hrep   <= n_hrep;
            r_vrep   <= n_vrep;
        end
    end

    assign o_wr_addr = r_loaded[ADDR_W-1:0];
    assign o_wr_data = i_pixel;
    assign o_rd_addr = r_src;

endmodule

// ===== rtl/ipru_out.sv =====
// Read-data stage and output register of the upscaler stream.
module ipru_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_en,
    input  ipru_pkg::t_meta              i_meta,
    input  logic [ipru_pkg::PIXEL_W-1:0] i_rd_data,
    output logic                         o_ready,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [ipru_pkg::PIXEL_W-1:0] o_m_tdata,
    output logic                         o_m_tlast,
    output logic [ipru_pkg::OUSER_W-1:0] o_m_tuser
);
    import ipru_pkg::*;

    logic               r_s1_valid;
    t_meta              r_s1_meta;
    logic               r_o_valid;
    logic [PIXEL_W-1:0] r_o_data;
    logic               r_o_last;
    logic [OUSER_W-1:0] r_o_user;
    logic               move;

    assign move    = r_s1_valid && (!r_o_valid || i_m_tready);
    assign o_ready = !r_s1_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_item_en;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_item_en) begin
            r_s1_meta <= i_meta;
        end
        if (move) begin
            // No pixel was read for loads and idle pulls: the data field is zero.
            r_o_data                    <= r_s1_meta.pixel_valid ? i_rd_data : '0;
            r_o_last                    <= r_s1_meta.end_of_line;
            r_o_user[OUSER_PIXEL_VALID] <= r_s1_meta.pixel_valid;
            r_o_user[OUSER_END_BLOCK]   <= r_s1_meta.end_of_block;
            r_o_user[OUSER_REJECTED]    <= r_s1_meta.load_rejected;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_user;

endmodule

// ===== rtl/integer_pixel_replication_upscaler_unit.sv =====
// Top level of the integer pixel replication upscaler.
//
//  Channel   Dir  Signals                          Contents
//  input     in   i_s_tvalid/o_s_tready            tdata red, green, blue; tuser command
//  output    out  o_m_tvalid/i_m_tready            tdata red, green, blue; tlast end of line;
//                                                   tuser pixel valid, end of block, rejected
//  config    in   i_cfg_valid/o_cfg_ready          index 0 scale factor, 1 input width
//
// One item is accepted per clock unless the output stalls; each gives exactly one result
// item via the read stage and output register. Replay counters and store port set the rate.
// Reset is synchronous and active low; the line store needs no clearing pass.
// A stalled output holds in the output register while the read stage still takes one item.
module integer_pixel_replication_upscaler_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ipru_pkg::PIXEL_W-1:0]   i_s_tdata,   // red_in, green_in, blue_in
    input  logic                           i_s_tuser,   // command
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ipru_pkg::PIXEL_W-1:0]   o_m_tdata,   // red_out, green_out, blue_out
    output logic                           o_m_tlast,   // end_of_line
    output logic [ipru_pkg::OUSER_W-1:0]   o_m_tuser,   // pixel_valid, end_of_block,
                                                        // load_rejected
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ipru_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ipru_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ipru_pkg::*;

    logic               item_en;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PIXEL_W-1:0] rd_data;
    t_meta              meta;
    logic               ready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = ready;
    assign item_en     = i_s_tvalid && ready;

    ipru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item_en   (item_en),
        .i_command   (i_s_tuser),
        .i_pixel     (i_s_tdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_meta      (meta)
    );

    ipru_line_ram #(
        .ADDR_BITS (ADDR_W),
        .DATA_BITS (PIXEL_W)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ipru_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_en  (item_en),
        .i_meta     (meta),
        .i_rd_data  (rd_data),
        .o_ready    (ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
